>>> sv/trma_pkg.sv
// trma_pkg: shared types and constants for the token ring membership arbiter
// used by trma_ctrl, trma_dp and token_ring_membership_arbiter; no dependencies
package trma_pkg;

  localparam int MAX_NODES = 32;
  localparam int SLOT_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NAME_W    = 64;
  localparam int FRAME_W   = 64;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_PASS    = 2'd2,
    CMD_DELIVER = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_FEW     = 3'd2,
    ST_NOTOKEN = 3'd3,
    ST_ABSENT  = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    latch;
    logic    do_add;
    logic    do_remove;
    logic    do_pass;
    logic    do_deliver;
    logic    rd_token;
    logic    rd_search;
    logic    search_clr;
    logic    set_status;
    status_t status_code;
    logic    emit;
  } dp_ctl_t;

  // datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic occ_zero;
    logic occ_full;
    logic occ_lt2;
    logic src_match;
    logic srch_hit;
    logic srch_miss;
  } dp_stat_t;

endpackage

>>> sv/trma_dp.sv
// trma_dp: ring datapath - name and frame memories, head/occupancy/token
// registers, search index and result registers; depends on trma_pkg
module trma_dp import trma_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_ctl_t             ctl,
  output dp_stat_t            stat,
  input  logic [1:0]          in_cmd,
  input  logic [NAME_W-1:0]   in_station_name,
  input  logic [NAME_W-1:0]   in_source_name,
  input  logic [NAME_W-1:0]   in_dest_name,
  input  logic [FRAME_W-1:0]  in_frame_word,
  output logic                out_valid,
  output logic [NAME_W-1:0]   out_holder_name,
  output logic                out_holder_valid,
  output logic [CNT_W-1:0]    out_station_count,
  output logic [2:0]          out_status
);

  localparam logic [CNT_W:0] MAX_EXT = (CNT_W + 1)'(MAX_NODES);

  // slot at a distance from base, with wrap
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= MAX_EXT) begin
      sum = sum - MAX_EXT;
    end
    return sum[SLOT_W-1:0];
  endfunction

  // distance of a slot from the oldest station
  function automatic logic [CNT_W-1:0] offset_of(input logic [SLOT_W-1:0] slot,
                                                 input logic [SLOT_W-1:0] head);
    logic [CNT_W:0] d;
    if (slot >= head) begin
      d = (CNT_W + 1)'(slot) - (CNT_W + 1)'(head);
    end else begin
      d = (CNT_W + 1)'(slot) + MAX_EXT - (CNT_W + 1)'(head);
    end
    return d[CNT_W-1:0];
  endfunction

  logic [NAME_W-1:0]  names_mem  [MAX_NODES];
  logic [FRAME_W-1:0] frames_mem [MAX_NODES];

  cmd_t               cmd_r;
  logic [NAME_W-1:0]  station_r;
  logic [NAME_W-1:0]  source_r;
  logic [NAME_W-1:0]  dest_r;
  logic [FRAME_W-1:0] frame_r;
  status_t            status_r;

  logic [SLOT_W-1:0]  head_r,  head_nxt;
  logic [CNT_W-1:0]   occ_r,   occ_nxt;
  logic [SLOT_W-1:0]  token_r, token_nxt;
  logic [CNT_W-1:0]   idx_r,   idx_nxt;
  logic               srch_vld_r, srch_vld_nxt;

  logic [NAME_W-1:0]  rdata_r;
  logic [SLOT_W-1:0]  rd_slot_r;
  logic [SLOT_W-1:0]  rd_addr;
  logic               rd_en;
  logic [SLOT_W-1:0]  add_slot;
  logic [CNT_W-1:0]   pass_off;
  logic [CNT_W-1:0]   pass_off_inc;

  logic               out_valid_r;
  logic [NAME_W-1:0]  out_holder_name_r;
  logic               out_holder_valid_r;
  logic [CNT_W-1:0]   out_station_count_r;
  logic [2:0]         out_status_r;

  assign add_slot     = slot_add(head_r, occ_r);
  assign pass_off     = offset_of(token_r, head_r);
  assign pass_off_inc = pass_off + CNT_W'(1);
  assign rd_en        = ctl.rd_token | ctl.rd_search;
  assign rd_addr      = ctl.rd_search ? slot_add(head_r, idx_r) : token_r;

  always_comb begin
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    token_nxt    = token_r;
    idx_nxt      = idx_r;
    srch_vld_nxt = srch_vld_r;
    if (ctl.do_add) begin
      token_nxt = add_slot;
      occ_nxt   = occ_r + CNT_W'(1);
    end
    if (ctl.do_remove) begin
      if (token_r == head_r) begin
        token_nxt = slot_add(head_r, CNT_W'(1));
      end
      head_nxt = slot_add(head_r, CNT_W'(1));
      occ_nxt  = occ_r - CNT_W'(1);
    end
    if (ctl.do_pass) begin
      // the newest station hands the token back to the oldest
      if (pass_off_inc >= occ_r) begin
        token_nxt = head_r;
      end else begin
        token_nxt = slot_add(head_r, pass_off_inc);
      end
    end
    if (ctl.do_deliver) begin
      token_nxt = rd_slot_r;
    end
    if (ctl.search_clr) begin
      idx_nxt      = '0;
      srch_vld_nxt = 1'b0;
    end else if (ctl.rd_search) begin
      srch_vld_nxt = (idx_r != occ_r);
      if (idx_r != occ_r) begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end else begin
      srch_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      occ_r      <= '0;
      token_r    <= '0;
      idx_r      <= '0;
      srch_vld_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      occ_r      <= occ_nxt;
      token_r    <= token_nxt;
      idx_r      <= idx_nxt;
      srch_vld_r <= srch_vld_nxt;
    end
  end

  // command capture and status code
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r     <= cmd_t'(in_cmd);
      station_r <= in_station_name;
      source_r  <= in_source_name;
      dest_r    <= in_dest_name;
      frame_r   <= in_frame_word;
      status_r  <= ST_OK;
    end else if (ctl.set_status) begin
      status_r  <= ctl.status_code;
    end
  end

  // ring memories, one read port with registered data
  always_ff @(posedge clk) begin
    if (ctl.do_add) begin
      names_mem[add_slot]  <= station_r;
      frames_mem[add_slot] <= '0;
    end
    if (ctl.do_deliver) begin
      frames_mem[rd_slot_r] <= frame_r;
    end
    if (rd_en) begin
      rdata_r   <= names_mem[rd_addr];
      rd_slot_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_holder_name_r   <= (occ_r != '0) ? rdata_r : '0;
      out_holder_valid_r  <= (occ_r != '0);
      out_station_count_r <= occ_r;
      out_status_r        <= status_r;
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.occ_zero  = (occ_r == '0);
  assign stat.occ_full  = (occ_r >= CNT_W'(MAX_NODES));
  assign stat.occ_lt2   = (occ_r < CNT_W'(2));
  assign stat.src_match = (rdata_r == source_r);
  assign stat.srch_hit  = srch_vld_r && (rdata_r == dest_r);
  assign stat.srch_miss = (idx_r == occ_r) && !srch_vld_r;

  assign out_valid         = out_valid_r;
  assign out_holder_name   = out_holder_name_r;
  assign out_holder_valid  = out_holder_valid_r;
  assign out_station_count = out_station_count_r;
  assign out_status        = out_status_r;

endmodule

>>> sv/trma_ctrl.sv
// trma_ctrl: command sequencer for the token ring arbiter
// drives trma_dp through dp_ctl_t and reads dp_stat_t; depends on trma_pkg
module trma_ctrl import trma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output dp_ctl_t  ctl,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRC_CMP,
    S_SEARCH,
    S_HOLD_RD,
    S_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    busy_nxt  = busy_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.latch = 1'b1;
          busy_nxt  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_HOLD_RD;
        case (stat.cmd)
          CMD_ADD: begin
            if (stat.occ_full) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_FULL;
            end else begin
              ctl.do_add = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (stat.occ_lt2) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_FEW;
            end else begin
              ctl.do_remove = 1'b1;
            end
          end
          CMD_PASS: begin
            if (stat.occ_lt2) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_FEW;
            end else begin
              ctl.do_pass = 1'b1;
            end
          end
          CMD_DELIVER: begin
            if (stat.occ_zero) begin
              ctl.set_status  = 1'b1;
              ctl.status_code = ST_NOTOKEN;
            end else begin
              // fetch the holder's name to check the sender
              ctl.rd_token = 1'b1;
              state_nxt    = S_SRC_CMP;
            end
          end
          default: begin
            state_nxt = S_HOLD_RD;
          end
        endcase
      end
      S_SRC_CMP: begin
        if (!stat.src_match) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = ST_NOTOKEN;
          state_nxt       = S_HOLD_RD;
        end else begin
          ctl.search_clr = 1'b1;
          state_nxt      = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // one read issued per cycle; the compare works on the registered read data
        if (stat.srch_hit) begin
          ctl.do_deliver = 1'b1;
          state_nxt      = S_HOLD_RD;
        end else if (stat.srch_miss) begin
          ctl.set_status  = 1'b1;
          ctl.status_code = ST_ABSENT;
          state_nxt       = S_HOLD_RD;
        end else begin
          ctl.rd_search = 1'b1;
        end
      end
      S_HOLD_RD: begin
        ctl.rd_token = 1'b1;
        state_nxt    = S_REPORT;
      end
      S_REPORT: begin
        ctl.emit  = 1'b1;
        busy_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        busy_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> sv/token_ring_membership_arbiter.sv
// token_ring_membership_arbiter: top level of the token ring arbiter
// joins trma_ctrl and trma_dp; depends on trma_pkg
//
// Usage:
//   A command is transferred at a rising edge with start high and busy low;
//   in_cmd selects add, remove oldest, pass token or deliver frame, and the
//   name and frame ports carry its operands. busy stays high until the
//   command's result has been produced.
//   Each command gives exactly one result: out_valid is high for one cycle
//   with out_holder_name, out_holder_valid, out_station_count and out_status.
//   The receiver cannot stall; the result is taken in that cycle.
// Search and throughput:
//   The search for a deliver walks the single read port of the name memory
//   one station per cycle, over the whole ring when the destination is
//   absent; a deliver refused for its sender or on an empty ring does no
//   search. A new command can be transferred in the cycle that out_valid
//   is high.
// Reset:
//   rst_n low clears the ring to empty with the token at slot zero; the
//   name and frame memories are not cleared and need no sweep.
module token_ring_membership_arbiter import trma_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_cmd,
  input  logic [NAME_W-1:0]   in_station_name,
  input  logic [NAME_W-1:0]   in_source_name,
  input  logic [NAME_W-1:0]   in_dest_name,
  input  logic [FRAME_W-1:0]  in_frame_word,
  output logic                out_valid,
  output logic [NAME_W-1:0]   out_holder_name,
  output logic                out_holder_valid,
  output logic [CNT_W-1:0]    out_station_count,
  output logic [2:0]          out_status
);

  dp_ctl_t  ctl;
  dp_stat_t stat;

  trma_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  trma_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .in_cmd            (in_cmd),
    .in_station_name   (in_station_name),
    .in_source_name    (in_source_name),
    .in_dest_name      (in_dest_name),
    .in_frame_word     (in_frame_word),
    .out_valid         (out_valid),
    .out_holder_name   (out_holder_name),
    .out_holder_valid  (out_holder_valid),
    .out_station_count (out_station_count),
    .out_status        (out_status)
  );

endmodule

>>> verif/token_ring_membership_arbiter_test.sv
// token_ring_membership_arbiter_test: self-checking testbench for the token ring arbiter
// runs a directed table and then phased random commands, checked against a ring predictor
// depends on trma_pkg and token_ring_membership_arbiter
`timescale 1ns / 100ps

module token_ring_membership_arbiter_test;
  import trma_pkg::*;

  typedef struct packed {
    logic [NAME_W-1:0] holder;
    logic              hvalid;
    logic [CNT_W-1:0]  count;
    status_t           status;
  } ring_result_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [NAME_W-1:0]  station;
    logic [NAME_W-1:0]  source;
    logic [NAME_W-1:0]  dest;
    logic [FRAME_W-1:0] frame;
    logic               typed;
    ring_result_t       want;
  } dir_row_t;

  localparam logic [NAME_W-1:0] NM_ONES = '1;
  localparam logic [NAME_W-1:0] NM_ZERO = '0;
  localparam logic [NAME_W-1:0] NM_ST1  = "STATION1";
  localparam logic [NAME_W-1:0] NM_NONE = "NOBODY!!";
  localparam logic [FRAME_W-1:0] FR_PAT = 64'h0123_4567_89ab_cdef;
  localparam int DIR_N      = 23;
  localparam int RAND_N     = 800;
  localparam int POOL_N     = 8;
  localparam int DRAIN_MAX  = 400;
  localparam int TAIL_WAIT  = 40;

  // typed rows: empty ring, single station, extremes of the name and the few and no-token error codes
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{CMD_REMOVE,  NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b1, '{NM_ZERO, 1'b0, 6'd0, ST_FEW}},
    '{CMD_PASS,    NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b1, '{NM_ZERO, 1'b0, 6'd0, ST_FEW}},
    '{CMD_DELIVER, NM_ZERO, NM_ZERO, NM_ZERO, '1,     1'b1, '{NM_ZERO, 1'b0, 6'd0, ST_NOTOKEN}},
    '{CMD_ADD,     NM_ONES, NM_ZERO, NM_ZERO, '0,     1'b1, '{NM_ONES, 1'b1, 6'd1, ST_OK}},
    '{CMD_PASS,    NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b1, '{NM_ONES, 1'b1, 6'd1, ST_FEW}},
    '{CMD_REMOVE,  NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b1, '{NM_ONES, 1'b1, 6'd1, ST_FEW}},
    '{CMD_DELIVER, NM_ZERO, NM_ZERO, NM_ONES, '1,     1'b1, '{NM_ONES, 1'b1, 6'd1, ST_NOTOKEN}},
    '{CMD_DELIVER, NM_ZERO, NM_ONES, NM_ONES, '1,     1'b1, '{NM_ONES, 1'b1, 6'd1, ST_OK}},
    '{CMD_ADD,     NM_ZERO, NM_ONES, NM_ONES, '1,     1'b1, '{NM_ZERO, 1'b1, 6'd2, ST_OK}},
    '{CMD_ADD,     NM_ST1,  NM_ZERO, NM_ZERO, '0,     1'b0, '0},
    '{CMD_ADD,     NM_ONES, NM_ZERO, NM_ZERO, '0,     1'b0, '0},
    // duplicate name: oldest match wins
    '{CMD_DELIVER, NM_ZERO, NM_ONES, NM_ONES, FR_PAT, 1'b0, '0},
    '{CMD_DELIVER, NM_ZERO, NM_ONES, NM_NONE, FR_PAT, 1'b0, '0},
    // wrong source and absent dest: source check comes first
    '{CMD_DELIVER, NM_ZERO, NM_ST1,  NM_NONE, FR_PAT, 1'b0, '0},
    '{CMD_DELIVER, NM_ZERO, NM_ONES, NM_ZERO, '0,     1'b0, '0},
    '{CMD_PASS,    NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b0, '0},
    '{CMD_PASS,    NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b0, '0},
    '{CMD_PASS,    NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b0, '0},
    '{CMD_REMOVE,  NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b0, '0},
    '{CMD_DELIVER, NM_ZERO, NM_ZERO, NM_ST1,  '1,     1'b0, '0},
    '{CMD_REMOVE,  NM_ONES, NM_ONES, NM_ONES, '1,     1'b0, '0},
    '{CMD_REMOVE,  NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b0, '0},
    '{CMD_REMOVE,  NM_ZERO, NM_ZERO, NM_ZERO, '0,     1'b0, '0}
  };

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_cmd;
  logic [NAME_W-1:0]  in_station_name;
  logic [NAME_W-1:0]  in_source_name;
  logic [NAME_W-1:0]  in_dest_name;
  logic [FRAME_W-1:0] in_frame_word;
  logic               out_valid;
  logic [NAME_W-1:0]  out_holder_name;
  logic               out_holder_valid;
  logic [CNT_W-1:0]   out_station_count;
  logic [2:0]         out_status;

  // predictor copy of the ring
  logic [NAME_W-1:0]  ring_name_mem  [MAX_NODES];
  logic [FRAME_W-1:0] ring_frame_mem [MAX_NODES];
  logic [SLOT_W-1:0]  oldest_slot;
  logic [CNT_W-1:0]   ring_occ;
  logic [SLOT_W-1:0]  holder_slot;

  ring_result_t expected_results[$];
  int fails;
  int cmds_sent;
  int results_seen;
  int peak_occ;
  int status_hits [5];

  token_ring_membership_arbiter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_station_name   (in_station_name),
    .in_source_name    (in_source_name),
    .in_dest_name      (in_dest_name),
    .in_frame_word     (in_frame_word),
    .out_valid         (out_valid),
    .out_holder_name   (out_holder_name),
    .out_holder_valid  (out_holder_valid),
    .out_station_count (out_station_count),
    .out_status        (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // apply one command to the predicted ring and return the result it yields
  task automatic ring_apply(input cmd_t c, input logic [NAME_W-1:0] st,
                            input logic [NAME_W-1:0] src, input logic [NAME_W-1:0] dst,
                            input logic [FRAME_W-1:0] frm, output ring_result_t r);
    status_t           code;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] off;
    logic              hit;
    code = ST_OK;
    hit  = 1'b0;
    s    = '0;
    case (c)
      CMD_ADD: begin
        if (ring_occ >= CNT_W'(MAX_NODES)) begin
          code = ST_FULL;
        end else begin
          s = oldest_slot + SLOT_W'(ring_occ);
          ring_name_mem[s]  = st;
          ring_frame_mem[s] = '0;
          holder_slot = s;
          ring_occ = ring_occ + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (ring_occ < 2) begin
          code = ST_FEW;
        end else begin
          if (holder_slot == oldest_slot) holder_slot = oldest_slot + 1'b1;
          oldest_slot = oldest_slot + 1'b1;
          ring_occ = ring_occ - 1'b1;
        end
      end
      CMD_PASS: begin
        if (ring_occ < 2) begin
          code = ST_FEW;
        end else begin
          off = holder_slot - oldest_slot;
          if (CNT_W'(off) + 1'b1 >= ring_occ) holder_slot = oldest_slot;
          else holder_slot = oldest_slot + off + 1'b1;
        end
      end
      default: begin
        if (ring_occ == 0 || ring_name_mem[holder_slot] != src) begin
          code = ST_NOTOKEN;
        end else begin
          for (int i = 0; i < MAX_NODES; i++) begin
            if (!hit && CNT_W'(i) < ring_occ &&
                ring_name_mem[oldest_slot + SLOT_W'(i)] == dst) begin
              hit = 1'b1;
              s = oldest_slot + SLOT_W'(i);
            end
          end
          if (!hit) begin
            code = ST_ABSENT;
          end else begin
            ring_frame_mem[s] = frm;
            holder_slot = s;
          end
        end
      end
    endcase
    r.holder = (ring_occ != 0) ? ring_name_mem[holder_slot] : '0;
    r.hvalid = (ring_occ != 0);
    r.count  = ring_occ;
    r.status = code;
    status_hits[code]++;
    if (int'(ring_occ) > peak_occ) peak_occ = int'(ring_occ);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input cmd_t c, input logic [NAME_W-1:0] st,
                          input logic [NAME_W-1:0] src, input logic [NAME_W-1:0] dst,
                          input logic [FRAME_W-1:0] frm, input logic typed,
                          input ring_result_t want);
    ring_result_t r;
    start           <= 1'b1;
    in_cmd          <= c;
    in_station_name <= st;
    in_source_name  <= src;
    in_dest_name    <= dst;
    in_frame_word   <= frm;
    do @(posedge clk); while (busy);
    ring_apply(c, st, src, dst, frm, r);
    expected_results.push_back(typed ? want : r);
    cmds_sent++;
    @(negedge clk);
  endtask

  function automatic int pick_gap(input int idx);
    if (idx >= 300 && idx < 450) return 0;
    if ($urandom_range(0, 99) >= 16) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 45);
    return $urandom_range(1, 4);
  endfunction

  // stimulus
  initial begin
    logic [NAME_W-1:0]  name_pool [POOL_N];
    logic [NAME_W-1:0]  st, src, dst;
    logic [FRAME_W-1:0] frm;
    cmd_t               c;
    int                 roll, gap, drain;
    int                 w_add, w_rem, w_pass;
    fails = 0;
    cmds_sent = 0;
    results_seen = 0;
    peak_occ = 0;
    foreach (status_hits[k]) status_hits[k] = 0;
    oldest_slot = '0;
    ring_occ    = '0;
    holder_slot = '0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_cmd          = CMD_ADD;
    in_station_name = '0;
    in_source_name  = '0;
    in_dest_name    = '0;
    in_frame_word   = '0;
    name_pool[0] = NM_ONES;
    name_pool[1] = NM_ZERO;
    name_pool[2] = NM_ST1;
    name_pool[3] = "NODE_007";
    for (int k = 4; k < POOL_N; k++) name_pool[k] = {$urandom, $urandom};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_cmd(DIR_TAB[i].cmd, DIR_TAB[i].station, DIR_TAB[i].source, DIR_TAB[i].dest,
               DIR_TAB[i].frame, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    for (int i = 0; i < RAND_N; i++) begin
      // phases swing the ring between nearly empty and full
      case ((i / 100) % 4)
        0:       begin w_add = 50; w_rem = 10; w_pass = 15; end
        1:       begin w_add = 30; w_rem = 10; w_pass = 20; end
        2:       begin w_add = 10; w_rem = 45; w_pass = 20; end
        default: begin w_add = 25; w_rem = 25; w_pass = 20; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < w_add) c = CMD_ADD;
      else if (roll < w_add + w_rem) c = CMD_REMOVE;
      else if (roll < w_add + w_rem + w_pass) c = CMD_PASS;
      else c = CMD_DELIVER;
      st  = {$urandom, $urandom};
      src = {$urandom, $urandom};
      dst = {$urandom, $urandom};
      frm = {$urandom, $urandom};
      if (c == CMD_ADD && $urandom_range(0, 1) == 0)
        st = name_pool[$urandom_range(0, POOL_N - 1)];
      if (c == CMD_DELIVER) begin
        roll = $urandom_range(0, 99);
        if (roll < 80 && ring_occ != 0) src = ring_name_mem[holder_slot];
        else if (roll < 90) src = name_pool[$urandom_range(0, POOL_N - 1)];
        roll = $urandom_range(0, 99);
        if (roll < 75 && ring_occ != 0)
          dst = ring_name_mem[oldest_slot + SLOT_W'($urandom_range(0, int'(ring_occ) - 1))];
        else if (roll < 90) dst = name_pool[$urandom_range(0, POOL_N - 1)];
      end
      gap = pick_gap(i);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      send_cmd(c, st, src, dst, frm, 1'b0, '0);
    end
    start <= 1'b0;

    drain = 0;
    while (expected_results.size() != 0 && drain < DRAIN_MAX) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fails++;
    end

    $display("%0d commands sent, %0d results checked, ring occupancy peaked at %0d",
             cmds_sent, results_seen, peak_occ);
    $display("status mix: ok %0d, full %0d, few %0d, no token %0d, absent %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_FEW],
             status_hits[ST_NOTOKEN], status_hits[ST_ABSENT]);
    if (fails == 0) begin
      $display("token_ring_membership_arbiter_test passed");
    end else begin
      $display("token_ring_membership_arbiter_test failed");
    end
    $finish;
  end

  // result checking against the oldest pending expectation
  always @(posedge clk) begin
    ring_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: holder %h status %0d",
               out_holder_name, out_status);
        fails++;
      end else begin
        want = expected_results.pop_front();
        if (out_holder_name !== want.holder) begin
          $error("holder_name expected %h actual %h", want.holder, out_holder_name);
          fails++;
        end
        if (out_holder_valid !== want.hvalid) begin
          $error("holder_valid expected %0d actual %0d", want.hvalid, out_holder_valid);
          fails++;
        end
        if (out_station_count !== want.count) begin
          $error("station_count expected %0d actual %0d", want.count, out_station_count);
          fails++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_status);
          fails++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("token_ring_membership_arbiter_test failed");
    $finish;
  end

endmodule

>>> token_ring_membership_arbiter.f
sv/trma_pkg.sv
sv/trma_dp.sv
sv/trma_ctrl.sv
sv/token_ring_membership_arbiter.sv
verif/token_ring_membership_arbiter_test.sv
